@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define QTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must never be true outside reset.
`define QTE_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/qte_pkg.sv @@
`default_nettype none

package qte_pkg;

  localparam int COMPONENT_FRAC_BITS = 14;
  localparam int ANGLE_TABLE_BITS    = 24;
  localparam int ANGLE_FRAC_BITS     = 7;
  localparam int CORDIC_STEPS        = 28;
  localparam int ISQRT_STAGES        = 31;
  localparam int ROUND_SHIFT         = ANGLE_TABLE_BITS - ANGLE_FRAC_BITS;

  localparam int QW = 16;  // component width
  localparam int PW = 32;  // product width
  localparam int SW = 34;  // product sum width
  localparam int CW = 36;  // CORDIC datapath width
  localparam int AW = 34;  // internal angle width
  localparam int VW = 62;  // square root radicand and work width
  localparam int RW = 31;  // square root result width
  localparam int OW = AW - ROUND_SHIFT;  // rounded angle width

  // Cycles from an accepted word to its result strobe.
  localparam int LATENCY = 3 + ISQRT_STAGES + 1 + CORDIC_STEPS + 1;

  localparam logic signed [SW-1:0] UNIT = SW'(64'sd1 <<< (2 * COMPONENT_FRAC_BITS));
  localparam logic signed [AW-1:0] DEG90 = AW'(64'sd90 <<< ANGLE_TABLE_BITS);
  localparam logic signed [OW-1:0] ROLL_LIM  = OW'(180 <<< ANGLE_FRAC_BITS);
  localparam logic signed [OW-1:0] PITCH_LIM = OW'(90 <<< ANGLE_FRAC_BITS);

  localparam logic signed [AW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7
  };

  typedef struct packed {
    logic signed [SW-1:0] r_sin;
    logic signed [SW-1:0] r_cos;
    logic signed [SW-1:0] y_sin;
    logic signed [SW-1:0] y_cos;
    logic                 clamp;
    logic                 clamp_pos;
    logic signed [RW-1:0] s30;
  } side_t;

  // Round half up to output resolution, then saturate to +/-lim.
  function automatic logic signed [OW-1:0] round_sat(input logic signed [AW-1:0] a,
                                                     input logic signed [OW-1:0] lim);
    logic signed [AW-1:0] s;
    logic signed [OW-1:0] r;
    s = a + AW'(64'sd1 <<< (ROUND_SHIFT - 1));
    r = s[AW-1:ROUND_SHIFT];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/qte_isqrt.sv @@
`default_nettype none

module qte_isqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [qte_pkg::VW-1:0]   rad_i,
  output logic                          valid_o,
  output logic [qte_pkg::RW-1:0]        root_o
);
  import qte_pkg::*;

  logic [VW-1:0] v_q [ISQRT_STAGES+1];
  logic [VW-1:0] r_q [ISQRT_STAGES+1];
  logic          ok_q [ISQRT_STAGES+1];

  assign v_q[0]  = rad_i;
  assign r_q[0]  = '0;
  assign ok_q[0] = valid_i;

  // One digit pair of the radicand is resolved in each stage.
  for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
    localparam logic [VW-1:0] BITC = VW'(1) << (2 * (ISQRT_STAGES - 1 - k));
    logic [VW-1:0] t;
    logic [VW-1:0] v_d, r_d;

    always_comb begin
      t = r_q[k] + BITC;
      if (v_q[k] >= t) begin
        v_d = v_q[k] - t;
        r_d = (r_q[k] >> 1) + BITC;
      end else begin
        v_d = v_q[k];
        r_d = r_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[k+1] <= v_d;
      r_q[k+1] <= r_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ok_q[k+1] <= 1'b0;
      end else begin
        ok_q[k+1] <= ok_q[k];
      end
    end
  end

  assign valid_o = ok_q[ISQRT_STAGES];
  assign root_o  = r_q[ISQRT_STAGES][RW-1:0];

endmodule

`default_nettype wire

@@ rtl/qte_cordic.sv @@
`default_nettype none

module qte_cordic (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic signed [qte_pkg::CW-1:0] y_i,
  input  wire logic signed [qte_pkg::CW-1:0] x_i,
  output logic                               valid_o,
  output logic signed [qte_pkg::AW-1:0]      angle_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [AW-1:0] a_q [CORDIC_STEPS+1];
  logic                 z_q [CORDIC_STEPS+1];
  logic                 ok_q [CORDIC_STEPS+1];

  logic signed [CW-1:0] x0_d, y0_d;
  logic signed [AW-1:0] a0_d;

  // Quadrant pre-rotation brings the vector into the right half plane.
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    a0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        a0_d = DEG90;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        a0_d = -DEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    a_q[0] <= a0_d;
    z_q[0] <= (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q[0] <= 1'b0;
    end else begin
      ok_q[0] <= valid_i;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        a_q[i+1] <= a_q[i] + ATAN_TAB[i];
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        a_q[i+1] <= a_q[i] - ATAN_TAB[i];
      end
      z_q[i+1] <= z_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ok_q[i+1] <= 1'b0;
      end else begin
        ok_q[i+1] <= ok_q[i];
      end
    end
  end

  assign valid_o = ok_q[CORDIC_STEPS];
  assign angle_o = z_q[CORDIC_STEPS] ? '0 : a_q[CORDIC_STEPS];

endmodule

`default_nettype wire

@@ rtl/quaternion_to_euler_top.sv @@
// Quaternion to roll, pitch and yaw. Components are signed with 1.0 = 16384;
// angles come out in 1/128 degree. A new word is taken in every clock cycle
// (busy_o stays low) and its result reaches valid_o through three product and
// sum stages, a 31-stage square root for the pitch cosine, a 29-stage CORDIC
// arctangent and an output rounding register. The receiver cannot stall the
// pipeline, so every result must be captured in the cycle that valid_o
// marks it.
`default_nettype none

module quaternion_to_euler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [qte_pkg::QW-1:0] quat_w_i,
  input  wire logic signed [qte_pkg::QW-1:0] quat_x_i,
  input  wire logic signed [qte_pkg::QW-1:0] quat_y_i,
  input  wire logic signed [qte_pkg::QW-1:0] quat_z_i,
  output logic                               valid_o,
  output logic signed [15:0]                 roll_angle_o,
  output logic signed [14:0]                 pitch_angle_o,
  output logic signed [15:0]                 yaw_angle_o,
  output logic                               pitch_clamped_o
);
  import qte_pkg::*;

  assign busy_o = 1'b0;

  // Stage 1: component products.
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, zz_q, wy_q, zx_q, wz_q, xy_q;
  logic                 v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    zx_q <= quat_z_i * quat_x_i;
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
  end

  // Stage 2: product sums and the pitch clamp test.
  logic signed [SW-1:0] p_sin;
  logic [SW-1:0]        p_mag;
  side_t                s2_d, s2_q;
  logic [RW-2:0]        mag_d, mag_q;
  logic                 neg_q;

  always_comb begin
    p_sin = (SW'(wy_q) - SW'(zx_q)) <<< 1;
    p_mag = (p_sin < 0) ? SW'(-p_sin) : SW'(p_sin);
    s2_d.r_sin = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    s2_d.r_cos = UNIT - ((SW'(xx_q) + SW'(yy_q)) <<< 1);
    s2_d.y_sin = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    s2_d.y_cos = UNIT - ((SW'(yy_q) + SW'(zz_q)) <<< 1);
    s2_d.clamp     = (p_sin >= UNIT) || (p_sin <= -UNIT);
    s2_d.clamp_pos = (p_sin > 0);
    s2_d.s30       = '0;
    // The sine is rescaled to 30 fraction bits before the square root.
    mag_d = {p_mag[2*COMPONENT_FRAC_BITS-1:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    s2_q  <= s2_d;
    mag_q <= mag_d;
    neg_q <= (p_sin < 0);
  end

  // Stage 3: cosine radicand 2^60 - s^2.
  side_t         s3_d, s3_q;
  logic [VW-1:0] rad_q;

  always_comb begin
    s3_d     = s2_q;
    s3_d.s30 = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  end

  always_ff @(posedge clk_i) begin
    s3_q  <= s3_d;
    rad_q <= (VW'(1) << 60) - (VW'(mag_q) * VW'(mag_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic          sq_valid;
  logic [RW-1:0] root;

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (rad_q),
    .valid_o (sq_valid),
    .root_o  (root)
  );

  // Side data travels alongside the square root stages.
  side_t side_q [ISQRT_STAGES];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s3_q;
    for (int k = 1; k < ISQRT_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  side_t sd;
  assign sd = side_q[ISQRT_STAGES-1];

  logic                 roll_v, pitch_v, yaw_v;
  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .y_i     (CW'(sd.r_sin)),
    .x_i     (CW'(sd.r_cos)),
    .valid_o (roll_v),
    .angle_o (roll_a)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .y_i     (CW'(sd.s30)),
    .x_i     ($signed({{(CW-RW){1'b0}}, root})),
    .valid_o (pitch_v),
    .angle_o (pitch_a)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .y_i     (CW'(sd.y_sin)),
    .x_i     (CW'(sd.y_cos)),
    .valid_o (yaw_v),
    .angle_o (yaw_a)
  );

  // Clamp flags follow the CORDIC stages.
  logic [1:0] cl_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    cl_q[0] <= {sd.clamp, sd.clamp_pos};
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      cl_q[k] <= cl_q[k-1];
    end
  end

  logic [1:0] cl;
  assign cl = cl_q[CORDIC_STEPS];

  logic signed [OW-1:0] roll_r, pitch_r, yaw_r;
  assign roll_r  = round_sat(roll_a, ROLL_LIM);
  assign yaw_r   = round_sat(yaw_a, ROLL_LIM);
  assign pitch_r = cl[1] ? (cl[0] ? PITCH_LIM : -PITCH_LIM) : round_sat(pitch_a, PITCH_LIM);

  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               clamp_q, out_v_q;

  always_ff @(posedge clk_i) begin
    roll_q  <= roll_r[15:0];
    yaw_q   <= yaw_r[15:0];
    pitch_q <= pitch_r[14:0];
    clamp_q <= cl[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= roll_v && pitch_v && yaw_v;
    end
  end

  assign valid_o         = out_v_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_clamped_o = clamp_q;

endmodule

`default_nettype wire

@@ rtl/qte_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module qte_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_o,
  input  wire logic                          valid_o,
  input  wire logic signed [15:0]            roll_angle_o,
  input  wire logic signed [14:0]            pitch_angle_o,
  input  wire logic signed [15:0]            yaw_angle_o,
  input  wire logic                          pitch_clamped_o
);
  import qte_pkg::*;

  logic pitch_at_lim, roll_in_range, yaw_in_range;

  assign pitch_at_lim  = (pitch_angle_o == 15'sd11520) || (pitch_angle_o == -15'sd11520);
  assign roll_in_range = (roll_angle_o <= 16'sd23040) && (roll_angle_o >= -16'sd23040);
  assign yaw_in_range  = (yaw_angle_o <= 16'sd23040) && (yaw_angle_o >= -16'sd23040);

  // A result word always traces back to a word taken a fixed time earlier.
  `QTE_ASSERT_IMPLY(a_latency, clk_i, rst_ni, valid_o, $past(start_i && !busy_o, LATENCY))

  // A clamped pitch is exactly plus or minus ninety degrees.
  `QTE_ASSERT_IMPLY(a_clamp, clk_i, rst_ni, valid_o && pitch_clamped_o, pitch_at_lim)

  // Roll and yaw stay within a half turn.
  `QTE_ASSERT_IMPLY(a_range, clk_i, rst_ni, valid_o, roll_in_range && yaw_in_range)

  // The pipeline never pushes back.
  `QTE_ASSERT_NEVER(a_nobusy, clk_i, rst_ni, busy_o)

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (.*);

`default_nettype wire
